[rtl/core/interval_timer_decrement_reload_unit_macros.svh]
// Assertion macros shared by the interval timer RTL.
`ifndef INTERVAL_TIMER_DECREMENT_RELOAD_UNIT_MACROS_SVH
`define INTERVAL_TIMER_DECREMENT_RELOAD_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ITDR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itdr assertion failed");
// next-cycle implication
`define ITDR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itdr assertion failed");
`else
`define ITDR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ITDR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/core/itdr_pkg.sv]
// Types and constants of the interval timer.
`timescale 1ns / 1ps
package itdr_pkg;
   localparam int unsigned SEC_W     = 27;
   localparam int unsigned USEC_W    = 20;
   localparam int unsigned TICK_W    = 20;
   localparam int unsigned IN_SEC_W  = 32;
   localparam int unsigned IN_USEC_W = 21;

   localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;
   localparam logic [USEC_W:0]   USEC_PER_SEC = 21'd1000000;
   localparam logic [SEC_W-1:0]  MAX_SEC      = 27'd100000000;
   localparam logic [TICK_W-1:0] TICK_RESET   = 20'd10000;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_DEC  = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_TICK = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic [SEC_W-1:0]  sec;
      logic [USEC_W-1:0] usec;
   } time_type;

   typedef struct packed {
      cmd_type                       cmd;
      logic signed [IN_SEC_W-1:0]    value_sec;
      logic signed [IN_USEC_W-1:0]   value_usec;
      logic signed [IN_SEC_W-1:0]    interval_sec;
      logic signed [IN_USEC_W-1:0]   interval_usec;
      logic [USEC_W-1:0]             dec_usec;
   } req_type;

   typedef struct packed {
      logic     load_error;
      logic     expired;
      logic     running;
      time_type remain;
   } rsp_type;

   typedef struct packed {
      logic     ok;
      time_type value;
      time_type reload;
   } load_type;

   typedef struct packed {
      logic     expired;
      time_type value;
   } dec_type;
endpackage

[rtl/core/itdr_part_check.sv]
// Range check and round-up to one tick of one seconds/microseconds pair.
`timescale 1ns / 1ps
module itdr_part_check (
   input  logic signed [itdr_pkg::IN_SEC_W-1:0]  sec,
   input  logic signed [itdr_pkg::IN_USEC_W-1:0] usec,
   input  logic [itdr_pkg::TICK_W-1:0]           tick,
   output logic                                  ok,
   output itdr_pkg::time_type                    part
);
   logic [itdr_pkg::USEC_W-1:0] usec_u;
   logic                        sec_ok;
   logic                        usec_ok;
   logic                        round_up;

   assign usec_u  = usec[itdr_pkg::USEC_W-1:0];
   assign sec_ok  = !sec[itdr_pkg::IN_SEC_W-1] &&
                    (sec[itdr_pkg::IN_SEC_W-2:0] <=
                     (itdr_pkg::IN_SEC_W-1)'(itdr_pkg::MAX_SEC));
   assign usec_ok = !usec[itdr_pkg::IN_USEC_W-1] &&
                    (usec_u < itdr_pkg::USEC_PER_SEC[itdr_pkg::USEC_W-1:0]);
   assign ok      = sec_ok && usec_ok;

   assign round_up  = (sec == '0) && (usec_u != '0) && (usec_u < tick);
   assign part.sec  = sec[itdr_pkg::SEC_W-1:0];
   assign part.usec = round_up ? tick : usec_u;
endmodule

[rtl/core/itdr_load_unit.sv]
// Load command: checks the new value and interval.
`timescale 1ns / 1ps
module itdr_load_unit (
   input  itdr_pkg::req_type            req,
   input  logic [itdr_pkg::TICK_W-1:0]  tick_us,
   output itdr_pkg::load_type           load
);
   logic [itdr_pkg::TICK_W-1:0] tick;
   logic                        value_ok;
   logic                        interval_ok;
   itdr_pkg::time_type          value_part;
   itdr_pkg::time_type          interval_part;
   logic                        value_zero;

   assign tick = (tick_us > itdr_pkg::USEC_MAX) ? itdr_pkg::USEC_MAX : tick_us;

   itdr_part_check u_value_check (
      .sec  (req.value_sec),
      .usec (req.value_usec),
      .tick (tick),
      .ok   (value_ok),
      .part (value_part)
   );

   itdr_part_check u_interval_check (
      .sec  (req.interval_sec),
      .usec (req.interval_usec),
      .tick (tick),
      .ok   (interval_ok),
      .part (interval_part)
   );

   // zero value disarms: interval is cleared and not checked
   assign value_zero  = (value_part == '0);
   assign load.ok     = value_ok && (value_zero || interval_ok);
   assign load.value  = value_part;
   assign load.reload = value_zero ? '0 : interval_part;
endmodule

[rtl/core/itdr_dec_unit.sv]
// Decrement command: borrow, expiry and reload less overshoot.
`timescale 1ns / 1ps
module itdr_dec_unit (
   input  itdr_pkg::time_type           value,
   input  itdr_pkg::time_type           reload,
   input  logic [itdr_pkg::USEC_W-1:0]  dec_usec,
   output itdr_pkg::dec_type            dec
);
   logic [itdr_pkg::USEC_W-1:0] amount;
   logic                        live;
   logic                        short_usec;
   logic                        under;
   logic [itdr_pkg::USEC_W-1:0] over;
   logic [itdr_pkg::SEC_W-1:0]  sub_sec;
   logic [itdr_pkg::USEC_W-1:0] sub_usec;
   logic                        fire;
   itdr_pkg::time_type          reload_val;

   assign amount     = (dec_usec > itdr_pkg::USEC_MAX) ? itdr_pkg::USEC_MAX : dec_usec;
   assign live       = (value != '0);
   assign short_usec = value.usec < amount;
   assign under      = short_usec && (value.sec == '0);
   assign over       = under ? (amount - value.usec) : '0;

   assign sub_sec  = short_usec ? (value.sec - 1'b1) : value.sec;
   assign sub_usec = short_usec ?
                     itdr_pkg::USEC_W'(({1'b0, value.usec} + itdr_pkg::USEC_PER_SEC)
                                       - {1'b0, amount}) :
                     (value.usec - amount);

   assign fire = live && (under || ((sub_sec == '0) && (sub_usec == '0)));

   always_comb begin
      reload_val = '0;
      if (reload != '0) begin
         if (reload.usec >= over) begin
            reload_val.sec  = reload.sec;
            reload_val.usec = reload.usec - over;
         end else if (reload.sec != '0) begin
            reload_val.sec  = reload.sec - 1'b1;
            reload_val.usec = itdr_pkg::USEC_W'(({1'b0, reload.usec} +
                                                itdr_pkg::USEC_PER_SEC) - {1'b0, over});
         end
      end
   end

   always_comb begin
      dec.expired = fire;
      if (!live) begin
         dec.value = value;
      end else if (fire) begin
         dec.value = reload_val;
      end else begin
         dec.value.sec  = sub_sec;
         dec.value.usec = sub_usec;
      end
   end
endmodule

[rtl/core/interval_timer_decrement_reload_unit.sv]
// Top level of the interval timer with decrement and reload.
//
// Request channel (req_*): one beat per command. tuser carries the command
// (0 = load value and interval, 1 = decrement by dec_usec); tdata carries
// the load fields and the decrement amount.
// Response channel (rsp_*): exactly one beat per request, in order. tuser
// flags a rejected load and an expiry; tdata gives running and the value
// left in seconds and microseconds.
// Config port (csr_*): register 0 at byte address 0 is tick_us, the
// microseconds per tick. Write it only while the timer is idle.
// An accepted request is held in the input register; its response is then
// registered in the response register. Throughput is one command per cycle
// while rsp_tready is high; the timer state is read and rewritten
// combinationally between the input register and the response register.
// Reset clears the value and interval to zero (timer stopped) and sets
// tick_us to 10000. When rsp_tready is low the response register holds,
// the input register still fills, and req_tready drops once both are full.
`timescale 1ns / 1ps
`include "interval_timer_decrement_reload_unit_macros.svh"
module interval_timer_decrement_reload_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // value_sec[31:0], value_usec[52:32],
                                    // interval_sec[84:53], interval_usec[105:85],
                                    // dec_usec[125:106], zero pad
   input  logic         req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // running[0], remain_sec[27:1],
                                    // remain_usec[47:28]
   output logic [1:0]   rsp_tuser,  // load_error[0], expired[1]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   logic [itdr_pkg::TICK_W-1:0] tick_ff, tick_in;
   itdr_pkg::req_type           req_ff, req_in, req_beat;
   logic                        req_valid_ff, req_valid_in;
   itdr_pkg::time_type          value_ff, value_in;
   itdr_pkg::time_type          reload_ff, reload_in;
   itdr_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        advance;
   logic                        csr_write;
   itdr_pkg::load_type          load;
   itdr_pkg::dec_type           dec;

   // config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tick_in = tick_ff;
      if (csr_write && (csr_paddr[2] == itdr_pkg::REG_TICK)) begin
         tick_in = csr_pwdata[itdr_pkg::TICK_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == itdr_pkg::REG_TICK) ?
                       {{(32 - itdr_pkg::TICK_W){1'b0}}, tick_ff} : '0;

   // request beat unpack
   always_comb begin
      req_beat.cmd           = itdr_pkg::cmd_type'(req_tuser);
      req_beat.value_sec     = req_tdata[31:0];
      req_beat.value_usec    = req_tdata[52:32];
      req_beat.interval_sec  = req_tdata[84:53];
      req_beat.interval_usec = req_tdata[105:85];
      req_beat.dec_usec      = req_tdata[125:106];
   end

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      req_in       = req_tready ? req_beat : req_ff;
      req_valid_in = req_tready ? req_tvalid : req_valid_ff;
   end

   itdr_load_unit u_load (
      .req     (req_ff),
      .tick_us (tick_ff),
      .load    (load)
   );

   itdr_dec_unit u_dec (
      .value    (value_ff),
      .reload   (reload_ff),
      .dec_usec (req_ff.dec_usec),
      .dec      (dec)
   );

   // state update and response
   always_comb begin
      value_in          = value_ff;
      reload_in         = reload_ff;
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         rsp_valid_in      = 1'b1;
         rsp_in.load_error = 1'b0;
         rsp_in.expired    = 1'b0;
         case (req_ff.cmd)
            itdr_pkg::CMD_LOAD: begin
               if (load.ok) begin
                  value_in  = load.value;
                  reload_in = load.reload;
               end else begin
                  rsp_in.load_error = 1'b1;
               end
            end
            itdr_pkg::CMD_DEC: begin
               value_in       = dec.value;
               rsp_in.expired = dec.expired;
            end
            default: begin
               value_in = value_ff;
            end
         endcase
         rsp_in.remain  = value_in;
         rsp_in.running = (value_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= itdr_pkg::TICK_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         value_ff     <= '0;
         reload_ff    <= '0;
      end else begin
         tick_ff      <= tick_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         value_ff     <= value_in;
         reload_ff    <= reload_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.expired, rsp_ff.load_error};
   assign rsp_tdata  = {rsp_ff.remain.usec, rsp_ff.remain.sec, rsp_ff.running};

   `ITDR_ASSERT_IMP(a_err_xor_exp, clock, reset, rsp_valid_ff,
                    !(rsp_ff.load_error && rsp_ff.expired))
   `ITDR_ASSERT_IMP(a_running_match, clock, reset, rsp_valid_ff,
                    rsp_ff.running == (rsp_ff.remain != '0))
   `ITDR_ASSERT_IMP(a_usec_range, clock, reset, 1'b1,
                    value_ff.usec <= itdr_pkg::USEC_MAX && reload_ff.usec <= itdr_pkg::USEC_MAX)
   `ITDR_ASSERT_NXT(a_reject_keeps, clock, reset,
                    advance && (req_ff.cmd == itdr_pkg::CMD_LOAD) && !load.ok,
                    $stable(value_ff) && $stable(reload_ff))
   `ITDR_ASSERT_NXT(a_stopped_stays, clock, reset,
                    advance && (req_ff.cmd == itdr_pkg::CMD_DEC) && (value_ff == '0),
                    (value_ff == '0) && !rsp_ff.expired)
endmodule
